@@ rtl/core/llrc_pkg.sv @@
// ----------------------------------------------------------------------------
// llrc_pkg
// shared types, codes and constants of the luma ramp controller
// ----------------------------------------------------------------------------
package llrc_pkg;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W = 21;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_LEVEL_MAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MIN_DELTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP_SIZE = 2'd2;

  localparam logic [LEVEL_W-1:0] RAW_LEVEL_MAX_RST  = 12'd4095;
  localparam logic [LEVEL_W-1:0] RAMP_MIN_DELTA_RST = 12'd700;
  localparam logic [LEVEL_W-1:0] RAMP_STEP_SIZE_RST = 12'd512;
  localparam logic [LEVEL_W-1:0] STEP_FLOOR         = 12'd64;

  // luma weights and scaling
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;
  localparam logic [PROD_W-1:0] ROUND_BIAS = 21'd127;
  localparam logic [PROD_W-1:0] DIV_BASE   = 21'd255;
  localparam logic [29:0]       DIV_RECIP  = 30'd257;

  // light kinds
  localparam logic [2:0] KIND_BACKLIGHT = 3'd0;
  localparam logic [2:0] KIND_ATTENTION = 3'd3;

  // write targets
  localparam logic [2:0] TGT_BACKLIGHT = 3'd0;
  localparam logic [2:0] TGT_RED       = 3'd1;
  localparam logic [2:0] TGT_GREEN     = 3'd2;
  localparam logic [2:0] TGT_BLUE      = 3'd3;
  localparam logic [2:0] TGT_NONE      = 3'd4;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_BAD_MODE  = 2'd1;
  localparam logic [1:0] STS_BAD_KIND  = 2'd2;

  typedef struct packed {
    logic [2:0]  light_kind;
    logic [23:0] color;
    logic        lp_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  write_target;
    logic [11:0] write_value;
    logic [1:0]  status_code;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_LUMA,
    ST_SCALE,
    ST_DIVIDE,
    ST_DECIDE,
    ST_RAMP,
    ST_GREEN,
    ST_BLUE
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_BAD_MODE,
    EMIT_BAD_KIND,
    EMIT_RED,
    EMIT_GREEN,
    EMIT_BLUE,
    EMIT_RAMP,
    EMIT_TARGET
  } emit_t;

  typedef struct packed {
    logic  load_in;
    logic  calc_luma;
    logic  calc_prod;
    logic  calc_div;
    logic  calc_ramp;
    logic  step_ramp;
    logic  commit_level;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic is_backlight;
    logic is_rgb;
    logic lp_req;
    logic out_free;
    logic ramp_more;
  } sts_t;

endpackage

@@ rtl/core/llrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// llrc_ctrl
// sequencer: steps each request through decode, scaling and the write run
// ----------------------------------------------------------------------------
module llrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  llrc_pkg::sts_t  sts,
  output llrc_pkg::cmd_t  cmd
);

  llrc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      llrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = llrc_pkg::ST_CLASS;
        end
      end
      llrc_pkg::ST_CLASS: begin
        if (sts.is_backlight && !sts.lp_req) begin
          state_next = llrc_pkg::ST_LUMA;
        end else if (sts.out_free) begin
          state_next = sts.is_rgb ? llrc_pkg::ST_GREEN : llrc_pkg::ST_IDLE;
        end
      end
      llrc_pkg::ST_LUMA:   state_next = llrc_pkg::ST_SCALE;
      llrc_pkg::ST_SCALE:  state_next = llrc_pkg::ST_DIVIDE;
      llrc_pkg::ST_DIVIDE: state_next = llrc_pkg::ST_DECIDE;
      llrc_pkg::ST_DECIDE: state_next = llrc_pkg::ST_RAMP;
      llrc_pkg::ST_RAMP: begin
        if (sts.out_free && !sts.ramp_more) begin
          state_next = llrc_pkg::ST_IDLE;
        end
      end
      llrc_pkg::ST_GREEN: begin
        if (sts.out_free) begin
          state_next = llrc_pkg::ST_BLUE;
        end
      end
      llrc_pkg::ST_BLUE: begin
        if (sts.out_free) begin
          state_next = llrc_pkg::ST_IDLE;
        end
      end
      default: state_next = llrc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.emit         = llrc_pkg::EMIT_NONE;
    case (state)
      llrc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      llrc_pkg::ST_CLASS: begin
        if (!(sts.is_backlight && !sts.lp_req) && sts.out_free) begin
          if (sts.is_backlight) begin
            cmd.emit = llrc_pkg::EMIT_BAD_MODE;
          end else if (sts.is_rgb) begin
            cmd.emit = llrc_pkg::EMIT_RED;
          end else begin
            cmd.emit = llrc_pkg::EMIT_BAD_KIND;
          end
        end
      end
      llrc_pkg::ST_LUMA:   cmd.calc_luma = 1'b1;
      llrc_pkg::ST_SCALE:  cmd.calc_prod = 1'b1;
      llrc_pkg::ST_DIVIDE: cmd.calc_div  = 1'b1;
      llrc_pkg::ST_DECIDE: cmd.calc_ramp = 1'b1;
      llrc_pkg::ST_RAMP: begin
        if (sts.out_free) begin
          if (sts.ramp_more) begin
            cmd.emit      = llrc_pkg::EMIT_RAMP;
            cmd.step_ramp = 1'b1;
          end else begin
            cmd.emit         = llrc_pkg::EMIT_TARGET;
            cmd.commit_level = 1'b1;
          end
        end
      end
      llrc_pkg::ST_GREEN: begin
        if (sts.out_free) begin
          cmd.emit = llrc_pkg::EMIT_GREEN;
        end
      end
      llrc_pkg::ST_BLUE: begin
        if (sts.out_free) begin
          cmd.emit = llrc_pkg::EMIT_BLUE;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/llrc_dp.sv @@
// ----------------------------------------------------------------------------
// llrc_dp
// datapath: config registers, luma, scaling divide, ramp counter, result reg
// ----------------------------------------------------------------------------
module llrc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [llrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [llrc_pkg::LEVEL_W-1:0]     cfg_data,
  input  llrc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output llrc_pkg::out_item_t              out_item,
  input  llrc_pkg::cmd_t                   cmd,
  output llrc_pkg::sts_t                   sts
);

  logic [11:0] raw_level_max;
  logic [11:0] ramp_min_delta;
  logic [11:0] ramp_step_size;
  logic [11:0] backlight_level;

  llrc_pkg::in_item_t req;
  logic [7:0]  luma;
  logic [20:0] prod;
  logic [11:0] target;
  logic        ramp_on;
  logic [12:0] ramp_val;

  logic [11:0] max_eff;
  logic [11:0] step_eff;
  logic [7:0]  red, green, blue;
  logic [15:0] luma_sum;
  logic [29:0] q_wide;
  logic [11:0] q_est;
  logic [20:0] rem;
  logic [11:0] q_fix;
  logic [11:0] target_next;
  llrc_pkg::out_item_t emit_item;

  // zero max acts as one, small steps floor at 64
  assign max_eff  = (raw_level_max == 12'd0) ? 12'd1 : raw_level_max;
  assign step_eff = (ramp_step_size < llrc_pkg::STEP_FLOOR) ? llrc_pkg::STEP_FLOOR
                                                            : ramp_step_size;

  assign red   = req.color[23:16];
  assign green = req.color[15:8];
  assign blue  = req.color[7:0];

  assign luma_sum = 16'(red) * llrc_pkg::LUMA_R + 16'(green) * llrc_pkg::LUMA_G
                  + 16'(blue) * llrc_pkg::LUMA_B;

  // x/255 as (x*257)>>16, low by at most one, fixed by a remainder check
  assign q_wide = 30'(prod) * llrc_pkg::DIV_RECIP;
  assign q_est  = q_wide[27:16];
  assign rem    = prod - 21'(q_est) * llrc_pkg::DIV_BASE;
  assign q_fix  = (rem >= llrc_pkg::DIV_BASE) ? q_est + 12'd1 : q_est;

  always_comb begin
    if (luma == 8'd0) begin
      target_next = 12'd0;
    end else if (q_fix == 12'd0) begin
      target_next = 12'd1;
    end else if (q_fix > max_eff) begin
      target_next = max_eff;
    end else begin
      target_next = q_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level_max   <= llrc_pkg::RAW_LEVEL_MAX_RST;
      ramp_min_delta  <= llrc_pkg::RAMP_MIN_DELTA_RST;
      ramp_step_size  <= llrc_pkg::RAMP_STEP_SIZE_RST;
      backlight_level <= 12'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          llrc_pkg::CFG_RAW_LEVEL_MAX:  raw_level_max  <= cfg_data;
          llrc_pkg::CFG_RAMP_MIN_DELTA: ramp_min_delta <= cfg_data;
          llrc_pkg::CFG_RAMP_STEP_SIZE: ramp_step_size <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit_level) begin
        backlight_level <= target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req <= in_item;
    end
    if (cmd.calc_luma) begin
      luma <= luma_sum[15:8];
    end
    if (cmd.calc_prod) begin
      prod <= 21'(luma) * 21'(max_eff) + llrc_pkg::ROUND_BIAS;
    end
    if (cmd.calc_div) begin
      target <= target_next;
    end
    if (cmd.calc_ramp) begin
      ramp_on  <= (target > backlight_level) &&
                  ((target - backlight_level) > ramp_min_delta);
      ramp_val <= 13'(backlight_level) + 13'(step_eff);
    end else if (cmd.step_ramp) begin
      ramp_val <= ramp_val + 13'(step_eff);
    end
  end

  always_comb begin
    emit_item = '{write_target: llrc_pkg::TGT_NONE, write_value: 12'd0,
                  status_code: llrc_pkg::STS_OK, last_of_run: 1'b1};
    case (cmd.emit)
      llrc_pkg::EMIT_BAD_MODE: emit_item.status_code = llrc_pkg::STS_BAD_MODE;
      llrc_pkg::EMIT_BAD_KIND: emit_item.status_code = llrc_pkg::STS_BAD_KIND;
      llrc_pkg::EMIT_RED: begin
        emit_item.write_target = llrc_pkg::TGT_RED;
        emit_item.write_value  = 12'(red);
        emit_item.last_of_run  = 1'b0;
      end
      llrc_pkg::EMIT_GREEN: begin
        emit_item.write_target = llrc_pkg::TGT_GREEN;
        emit_item.write_value  = 12'(green);
        emit_item.last_of_run  = 1'b0;
      end
      llrc_pkg::EMIT_BLUE: begin
        emit_item.write_target = llrc_pkg::TGT_BLUE;
        emit_item.write_value  = 12'(blue);
      end
      llrc_pkg::EMIT_RAMP: begin
        emit_item.write_target = llrc_pkg::TGT_BACKLIGHT;
        emit_item.write_value  = ramp_val[11:0];
        emit_item.last_of_run  = 1'b0;
      end
      llrc_pkg::EMIT_TARGET: begin
        emit_item.write_target = llrc_pkg::TGT_BACKLIGHT;
        emit_item.write_value  = target;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != llrc_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != llrc_pkg::EMIT_NONE) begin
      out_item <= emit_item;
    end
  end

  assign sts.is_backlight = (req.light_kind == llrc_pkg::KIND_BACKLIGHT);
  assign sts.is_rgb       = (req.light_kind != llrc_pkg::KIND_BACKLIGHT) &&
                            (req.light_kind <= llrc_pkg::KIND_ATTENTION);
  assign sts.lp_req       = req.lp_req;
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.ramp_more    = ramp_on && (ramp_val < 13'(target));

endmodule

@@ rtl/core/led_light_luma_ramp_controller_unit.sv @@
// ----------------------------------------------------------------------------
// led_light_luma_ramp_controller_unit
// backlight brightness ramp controller with rgb indicator writes
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  input     in_valid / in_ready     in_item   (light_kind, color, lp_req)
//  output    out_valid / out_ready   out_item  (write_target, write_value,
//                                               status_code, last_of_run)
//  config    cfg_we                  cfg_index, cfg_data (12 bit)
//
//  one request at a time; a result register lets the next item be taken
//  while the last result of a run still waits
//  refused kinds or low-persistence backlight: 1 result; rgb kinds: 3 results,
//  red, green and blue in that order, each as the result register frees
//  backlight: decode, luma, scale, divide and ramp setup in that order, then
//  one write per cycle paced by the ramp counter; out_ready low holds the run
//
module led_light_luma_ramp_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  llrc_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output llrc_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [llrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llrc_pkg::LEVEL_W-1:0]   cfg_data
);

  // command and status between sequencer and datapath
  llrc_pkg::cmd_t cmd;
  llrc_pkg::sts_t sts;

  llrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds config, current level, divide and the result register
  llrc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
